@@ rtl/core/patan_pkg.sv @@
package patan_pkg;

    localparam int COORD_WIDTH     = 16;
    localparam int ANGLE_FRAC_BITS = 13;
    localparam int OUT_W           = 16;

    // magnitude of the most negative coordinate still fits unsigned
    localparam int MAG_W      = COORD_WIDTH;
    localparam int RATIO_FRAC = 16;
    localparam int RATIO_W    = RATIO_FRAC + 1;
    localparam int DIV_STAGES = RATIO_FRAC;
    localparam int REM_W      = MAG_W + 1;

    // polynomial datapath in Q.30
    localparam int Q_FRAC     = 30;
    localparam int ACC_W      = 32;
    localparam int S_W        = Q_FRAC + 1;
    localparam int A_W        = Q_FRAC + 4;
    localparam int R30_SHIFT  = Q_FRAC - RATIO_FRAC;
    localparam int SQ_SHIFT   = 2 * RATIO_FRAC - Q_FRAC;
    localparam int OUT_SHIFT  = Q_FRAC - ANGLE_FRAC_BITS;

    localparam int HORNER_STEPS = 4;
    // fast mode skips the leading Horner steps
    localparam int FAST_SKIP    = 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    localparam logic signed [A_W-1:0] Q_PI      = A_W'(64'sd3373259426);
    localparam logic signed [A_W-1:0] Q_HALF_PI = A_W'(64'sd1686629713);

    localparam logic signed [ACC_W-1:0] COEF_PRECISE [HORNER_STEPS+1] = '{
        -32'sd13026979, 32'sd57639932, -32'sd129777902, 32'sd208190476, -32'sd357616157
    };
    localparam logic signed [ACC_W-1:0] COEF_FAST [HORNER_STEPS+1-FAST_SKIP] = '{
        -32'sd49925210, 32'sd171062341, -32'sd351782264
    };

    typedef struct packed {
        logic x_zero;
        logic y_zero;
        logic x_neg;
        logic y_neg;
        logic swap;
        logic equal;
        logic precise;
    } item_flags_t;

    typedef struct packed {
        item_flags_t      flags;
        logic [MAG_W-1:0] lo;
        logic [MAG_W-1:0] hi;
    } front_item_t;

    typedef struct packed {
        item_flags_t        flags;
        logic [RATIO_W-1:0] ratio;
    } div_item_t;

endpackage

@@ rtl/core/patan_front.sv @@
module patan_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [patan_pkg::COORD_WIDTH-1:0] y_coord,
    input  logic signed [patan_pkg::COORD_WIDTH-1:0] x_coord,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  precise_mode,
    output patan_pkg::front_item_t                item,
    output logic                                  item_valid,
    input  logic                                  item_ready
);
    import patan_pkg::*;

    logic             valid_reg;
    front_item_t      item_reg;
    front_item_t      item_next;
    logic [MAG_W-1:0] ay;
    logic [MAG_W-1:0] ax;

    always_comb
    begin
        ay = y_coord[COORD_WIDTH-1] ? MAG_W'(-y_coord) : MAG_W'(y_coord);
        ax = x_coord[COORD_WIDTH-1] ? MAG_W'(-x_coord) : MAG_W'(x_coord);
        item_next.flags.x_zero  = (x_coord == '0);
        item_next.flags.y_zero  = (y_coord == '0);
        item_next.flags.x_neg   = x_coord[COORD_WIDTH-1];
        item_next.flags.y_neg   = y_coord[COORD_WIDTH-1];
        item_next.flags.swap    = (ay > ax);
        item_next.flags.equal   = (ay == ax);
        item_next.flags.precise = precise_mode;
        item_next.lo            = (ay > ax) ? ax : ay;
        item_next.hi            = (ay > ax) ? ay : ax;
    end

    assign in_ready   = !valid_reg || item_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/core/patan_fifo.sv @@
module patan_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  patan_pkg::front_item_t wr_item,
    input  logic                   wr_valid,
    output logic                   wr_ready,
    output patan_pkg::front_item_t rd_item,
    output logic                   rd_valid,
    input  logic                   rd_ready
);
    import patan_pkg::*;

    front_item_t           slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    logic                  push;
    logic                  pop;

    assign wr_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("queue count beyond depth");

    a_ptr_match: assert property (@(posedge clk) disable iff (!rst_n)
        FIFO_PTR_W'(wr_ptr_reg - rd_ptr_reg) == count_reg[FIFO_PTR_W-1:0])
        else $error("queue pointers disagree with count");

    a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("transfer into queue lost");
`endif

endmodule

@@ rtl/core/patan_div.sv @@
module patan_div (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  patan_pkg::front_item_t item,
    input  logic                   item_valid,
    output patan_pkg::div_item_t   result,
    output logic                   result_valid
);
    import patan_pkg::*;

    logic [DIV_STAGES-1:0] valid_reg;
    logic [REM_W-1:0]      rem_reg   [DIV_STAGES];
    logic [REM_W-1:0]      rem_next  [DIV_STAGES];
    logic [DIV_STAGES-1:0] quo_reg   [DIV_STAGES];
    logic [DIV_STAGES-1:0] quo_next  [DIV_STAGES];
    logic [MAG_W-1:0]      hi_reg    [DIV_STAGES];
    logic [MAG_W-1:0]      hi_in     [DIV_STAGES];
    item_flags_t           flags_reg [DIV_STAGES];
    item_flags_t           flags_in  [DIV_STAGES];
    logic [REM_W-1:0]      rem_in    [DIV_STAGES];
    logic [DIV_STAGES-1:0] quo_in    [DIV_STAGES];
    logic [REM_W-1:0]      rem_sh    [DIV_STAGES];

    // one quotient bit per stage, restoring form
    always_comb
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (k == 0)
            begin
                rem_in[k]   = {1'b0, item.lo};
                quo_in[k]   = '0;
                hi_in[k]    = item.hi;
                flags_in[k] = item.flags;
            end
            else
            begin
                rem_in[k]   = rem_reg[k-1];
                quo_in[k]   = quo_reg[k-1];
                hi_in[k]    = hi_reg[k-1];
                flags_in[k] = flags_reg[k-1];
            end
            rem_sh[k] = {rem_in[k][REM_W-2:0], 1'b0};
            if (rem_sh[k] >= {1'b0, hi_in[k]})
            begin
                rem_next[k] = rem_sh[k] - {1'b0, hi_in[k]};
                quo_next[k] = {quo_in[k][DIV_STAGES-2:0], 1'b1};
            end
            else
            begin
                rem_next[k] = rem_sh[k];
                quo_next[k] = {quo_in[k][DIV_STAGES-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[DIV_STAGES-2:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                rem_reg[k]   <= rem_next[k];
                quo_reg[k]   <= quo_next[k];
                hi_reg[k]    <= hi_in[k];
                flags_reg[k] <= flags_in[k];
            end
        end
    end

    // equal magnitudes give exactly one
    assign result.flags  = flags_reg[DIV_STAGES-1];
    assign result.ratio  = flags_reg[DIV_STAGES-1].equal ? (RATIO_W'(1) << RATIO_FRAC)
                                                         : {1'b0, quo_reg[DIV_STAGES-1]};
    assign result_valid  = valid_reg[DIV_STAGES-1];

endmodule

@@ rtl/core/patan_poly.sv @@
module patan_poly (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  patan_pkg::div_item_t              item,
    input  logic                              item_valid,
    output logic signed [patan_pkg::OUT_W-1:0] angle,
    output logic                              angle_valid
);
    import patan_pkg::*;

    // square, Horner steps, last two products, fold, output
    localparam int NSTG    = HORNER_STEPS + 5;
    localparam int T_STG   = HORNER_STEPS + 1;
    localparam int A_STG   = HORNER_STEPS + 2;
    localparam int F_STG   = HORNER_STEPS + 3;

    logic [NSTG-1:0]          valid_reg;
    logic [RATIO_W-1:0]       ratio_reg [T_STG+1];
    item_flags_t              flags_reg [F_STG+1];
    logic [S_W-1:0]           s_reg     [HORNER_STEPS+1];
    logic signed [ACC_W-1:0]  acc_reg   [HORNER_STEPS+1];
    logic signed [ACC_W-1:0]  acc_next  [HORNER_STEPS+1];
    logic signed [ACC_W-1:0]  t_reg;
    logic signed [ACC_W-1:0]  t_next;
    logic signed [A_W-1:0]    a_reg;
    logic signed [A_W-1:0]    a_next;
    logic signed [A_W-1:0]    f_reg;
    logic signed [A_W-1:0]    f_next;
    logic signed [OUT_W-1:0]  angle_reg;
    logic signed [OUT_W-1:0]  angle_next;
    logic [2*RATIO_W-1:0]     sq;
    logic [S_W-1:0]           s_next;
    logic signed [ACC_W-1:0]  coef;
    logic                     step_on;
    logic signed [A_W-1:0]    r30;
    logic signed [ACC_W-1:0]  u;
    logic                     out_neg;
    logic [A_W-1:0]           f_mag;
    logic [A_W-1:0]           f_rnd;
    logic [OUT_W:0]           f_sat;
    logic signed [OUT_W:0]    v;

    // Q.30 product by s, rounded half away from zero
    function automatic logic signed [ACC_W-1:0] qmul_s(
        input logic signed [ACC_W-1:0] a,
        input logic [S_W-1:0]          s
    );
        logic [ACC_W-1:0]     mag;
        logic [ACC_W+S_W-1:0] prod;
        logic [ACC_W-1:0]     m;
        mag  = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
        prod = {{S_W{1'b0}}, mag} * {{ACC_W{1'b0}}, s};
        m    = ACC_W'((prod + ((ACC_W+S_W)'(1) << (Q_FRAC - 1))) >> Q_FRAC);
        return a[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    // product by r in Q.30, reduced to a product by the raw ratio
    function automatic logic signed [ACC_W-1:0] qmul_r(
        input logic signed [ACC_W-1:0] a,
        input logic [RATIO_W-1:0]      r
    );
        logic [ACC_W-1:0]         mag;
        logic [ACC_W+RATIO_W-1:0] prod;
        logic [ACC_W-1:0]         m;
        mag  = a[ACC_W-1] ? ACC_W'(-a) : ACC_W'(a);
        prod = {{RATIO_W{1'b0}}, mag} * {{ACC_W{1'b0}}, r};
        m    = ACC_W'((prod + ((ACC_W+RATIO_W)'(1) << (RATIO_FRAC - 1))) >> RATIO_FRAC);
        return a[ACC_W-1] ? -$signed(m) : $signed(m);
    endfunction

    always_comb
    begin
        sq     = {{RATIO_W{1'b0}}, item.ratio} * {{RATIO_W{1'b0}}, item.ratio};
        s_next = S_W'((sq + ((2*RATIO_W)'(1) << (SQ_SHIFT - 1))) >> SQ_SHIFT);
        acc_next[0] = item.flags.precise ? COEF_PRECISE[0] : COEF_FAST[0];
        coef    = '0;
        step_on = 1'b0;
        for (int k = 1; k <= HORNER_STEPS; k++)
        begin
            step_on = flags_reg[k-1].precise || (k > FAST_SKIP);
            coef    = flags_reg[k-1].precise ? COEF_PRECISE[k]
                                             : COEF_FAST[(k > FAST_SKIP) ? (k - FAST_SKIP) : 0];
            acc_next[k] = step_on ? qmul_s(acc_reg[k-1], s_reg[k-1]) + coef : acc_reg[k-1];
        end

        t_next = qmul_s(acc_reg[HORNER_STEPS], s_reg[HORNER_STEPS]);

        r30    = $signed(A_W'(ratio_reg[T_STG]) << R30_SHIFT);
        u      = qmul_r(t_reg, ratio_reg[T_STG]);
        a_next = r30 + A_W'(u);

        // octant and quadrant folds merge into one add against a constant
        if (flags_reg[A_STG].x_zero)
        begin
            f_next = flags_reg[A_STG].y_zero ? '0 : Q_HALF_PI;
        end
        else
        begin
            case ({flags_reg[A_STG].swap, flags_reg[A_STG].x_neg})
                2'b00:   f_next = a_reg;
                2'b10:   f_next = Q_HALF_PI - a_reg;
                2'b01:   f_next = Q_PI - a_reg;
                default: f_next = Q_HALF_PI + a_reg;
            endcase
        end

        out_neg = flags_reg[F_STG].y_neg ^ f_reg[A_W-1];
        f_mag   = f_reg[A_W-1] ? A_W'(-f_reg) : A_W'(f_reg);
        f_rnd   = (f_mag + (A_W'(1) << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        f_sat   = (f_rnd > A_W'(1 << (OUT_W - 1))) ? (OUT_W+1)'(1 << (OUT_W - 1))
                                                   : f_rnd[OUT_W:0];
        v       = out_neg ? -$signed(f_sat) : $signed(f_sat);
        if (v > $signed((OUT_W+1)'((1 << (OUT_W - 1)) - 1)))
        begin
            angle_next = OUT_W'((1 << (OUT_W - 1)) - 1);
        end
        else
        begin
            angle_next = v[OUT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NSTG-2:0], item_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ratio_reg[0] <= item.ratio;
            for (int k = 1; k <= T_STG; k++)
            begin
                ratio_reg[k] <= ratio_reg[k-1];
            end
            flags_reg[0] <= item.flags;
            for (int k = 1; k <= F_STG; k++)
            begin
                flags_reg[k] <= flags_reg[k-1];
            end
            s_reg[0] <= s_next;
            for (int k = 1; k <= HORNER_STEPS; k++)
            begin
                s_reg[k] <= s_reg[k-1];
            end
            for (int k = 0; k <= HORNER_STEPS; k++)
            begin
                acc_reg[k] <= acc_next[k];
            end
            t_reg     <= t_next;
            a_reg     <= a_next;
            f_reg     <= f_next;
            angle_reg <= angle_next;
        end
    end

    assign angle       = angle_reg;
    assign angle_valid = valid_reg[NSTG-1];

endmodule

@@ rtl/core/polynomial_atan2.sv @@
// Throughput: one item per cycle while out_ready stays high.
// 16 divider stages and 9 polynomial stages in series.
// A 4-entry queue lets the input side keep taking items while the output stalls.
// Reset (rst_n, async, active low) empties the pipeline and queue; precise_mode resets to 1.
module polynomial_atan2 (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic signed [patan_pkg::COORD_WIDTH-1:0] y_coord,
    input  logic signed [patan_pkg::COORD_WIDTH-1:0] x_coord,
    input  logic                                     in_valid,
    output logic                                     in_ready,
    output logic signed [patan_pkg::OUT_W-1:0]       angle,
    output logic                                     out_valid,
    input  logic                                     out_ready,
    input  logic                                     cfg_we,
    input  logic                                     cfg_wdata
);
    import patan_pkg::*;

    logic        precise_mode_reg;
    front_item_t front_item;
    logic        front_valid;
    logic        front_ready;
    front_item_t queue_item;
    logic        queue_valid;
    div_item_t   div_item;
    logic        div_valid;
    logic        back_en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            precise_mode_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            precise_mode_reg <= cfg_wdata;
        end
    end

    // back end advances as a whole whenever the output register frees up
    assign back_en = !out_valid || out_ready;

    patan_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .y_coord      (y_coord),
        .x_coord      (x_coord),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .precise_mode (precise_mode_reg),
        .item         (front_item),
        .item_valid   (front_valid),
        .item_ready   (front_ready)
    );

    patan_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_item  (front_item),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_item  (queue_item),
        .rd_valid (queue_valid),
        .rd_ready (back_en)
    );

    patan_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (back_en),
        .item         (queue_item),
        .item_valid   (queue_valid),
        .result       (div_item),
        .result_valid (div_valid)
    );

    patan_poly u_poly (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (back_en),
        .item        (div_item),
        .item_valid  (div_valid),
        .angle       (angle),
        .angle_valid (out_valid)
    );

endmodule

@@ test/tb_polynomial_atan2.sv @@
module tb_polynomial_atan2;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CYCLE_LIMIT = 200000;
    localparam int  HOLD_CYCLES = 150;
    localparam int  DRAIN_CYCLES = 40;
    localparam int  PHASES = 6;
    localparam int  PHASE_ITEMS = 120;
    localparam bit  MODE_FAST = 1'b0;
    localparam bit  MODE_PRECISE = 1'b1;

    // Q.30 polynomial coefficients, highest power first
    localparam longint P5_0 = -64'sd13026979;
    localparam longint P5_1 = 64'sd57639932;
    localparam longint P5_2 = -64'sd129777902;
    localparam longint P5_3 = 64'sd208190476;
    localparam longint P5_4 = -64'sd357616157;
    localparam longint P3_0 = -64'sd49925210;
    localparam longint P3_1 = 64'sd171062341;
    localparam longint P3_2 = -64'sd351782264;
    localparam longint Q30_PI = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;

    localparam logic signed [15:0] ANG_HALF_PI = 16'sd12868;
    localparam logic signed [15:0] ANG_PI = 16'sd25736;

    typedef struct packed {
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic               fixed;
        logic signed [15:0] angle;
    } stim_row_t;

    typedef struct {
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] angle;
    } angle_exp_t;

    localparam int DIR_ROWS = 22;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic signed [15:0] y_coord = '0;
    logic signed [15:0] x_coord = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] angle;
    logic out_valid;
    logic out_ready = 1'b0;
    logic cfg_we = 1'b0;
    logic cfg_wdata = 1'b0;

    angle_exp_t angle_q[$];
    stim_row_t  dir_rows [DIR_ROWS];
    int  errors = 0;
    int  cycles = 0;
    bit  model_precise = MODE_PRECISE;
    bit  tx_idle = 1'b1;
    bit  rx_idle = 1'b1;
    bit  hold_req = 1'b0;

    polynomial_atan2 dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .y_coord   (y_coord),
        .x_coord   (x_coord),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Q.30 product, rounded half away from zero
    function automatic longint round_mul(longint a, longint b);
        longint unsigned ma;
        longint unsigned mb;
        longint unsigned m;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? longint'(-a) : a;
        mb = (b < 0) ? longint'(-b) : b;
        m = (ma * mb + 64'd536870912) >> 30;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [15:0] predict_angle(logic signed [15:0] yc,
                                                         logic signed [15:0] xc,
                                                         bit precise);
        longint yv;
        longint xv;
        longint unsigned ay;
        longint unsigned ax;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mag;
        longint r30;
        longint sq;
        longint acc;
        longint a;
        longint v;
        yv = yc;
        xv = xc;
        if (xv == 0)
        begin
            a = (yv > 0) ? Q30_HALF_PI : (yv < 0) ? -Q30_HALF_PI : 0;
        end
        else
        begin
            ay = (yv < 0) ? -yv : yv;
            ax = (xv < 0) ? -xv : xv;
            lo = (ay < ax) ? ay : ax;
            hi = (ay < ax) ? ax : ay;
            r30 = longint'(((lo << 16) / hi) << 14);
            sq = round_mul(r30, r30);
            if (precise)
            begin
                acc = round_mul(P5_0, sq) + P5_1;
                acc = round_mul(acc, sq) + P5_2;
                acc = round_mul(acc, sq) + P5_3;
                acc = round_mul(acc, sq) + P5_4;
            end
            else
            begin
                acc = round_mul(P3_0, sq) + P3_1;
                acc = round_mul(acc, sq) + P3_2;
            end
            a = r30 + round_mul(round_mul(acc, sq), r30);
            if (ay > ax)
                a = Q30_HALF_PI - a;
            if (xv < 0)
                a = Q30_PI - a;
            if (yv < 0)
                a = -a;
        end
        mag = (a < 0) ? -a : a;
        mag = (mag + 64'd65536) >> 17;
        if (mag > 32768)
            mag = 32768;
        v = (a < 0) ? -longint'(mag) : longint'(mag);
        if (v > 32767)
            v = 32767;
        return v[15:0];
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        errors++;
    endtask

    task automatic send_coords(logic signed [15:0] yc, logic signed [15:0] xc,
                               bit fixed, logic signed [15:0] fixed_angle);
        int gap;
        angle_exp_t e;
        gap = tx_idle ? $urandom_range(0, 4) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        y_coord <= yc;
        x_coord <= xc;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        e.y = yc;
        e.x = xc;
        e.angle = fixed ? fixed_angle : predict_angle(yc, xc, model_precise);
        angle_q.push_back(e);
    endtask

    // drop valid and wait for every outstanding angle
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (angle_q.size() != 0) @(posedge clk);
    endtask

    task automatic set_precision(bit mode);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= mode;
        @(negedge clk);
        cfg_we <= 1'b0;
        model_precise = mode;
    endtask

    task automatic random_coords(output logic signed [15:0] yc, output logic signed [15:0] xc);
        logic signed [15:0] m;
        logic signed [15:0] pick [6];
        pick = '{-16'sd32768, -16'sd32767, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
        case ($urandom_range(0, 9)) inside
            [0:4]:
            begin
                yc = 16'($urandom);
                xc = 16'($urandom);
            end
            [5:6]:
            begin
                yc = $signed(16'($urandom_range(0, 64))) - 16'sd32;
                xc = $signed(16'($urandom_range(0, 64))) - 16'sd32;
            end
            7:
            begin
                yc = 16'($urandom);
                xc = 16'($urandom);
                if ($urandom_range(0, 1))
                    xc = '0;
                else
                    yc = '0;
            end
            8:
            begin
                m = 16'($urandom);
                yc = $urandom_range(0, 1) ? -m : m;
                xc = $urandom_range(0, 1) ? -m : m;
            end
            default:
            begin
                yc = pick[$urandom_range(0, 5)];
                xc = pick[$urandom_range(0, 5)];
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        angle_exp_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (angle_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected angle %0d", angle));
            end
            else
            begin
                e = angle_q.pop_front();
                if (angle !== e.angle)
                    report_mismatch($sformatf("y=%0d x=%0d angle=%0d expected %0d",
                                              e.y, e.x, angle, e.angle));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("tb_polynomial_atan2 NOT OK");
            $finish;
        end
    end

    // receiver: random stall per transfer, plus one long hold-off on request
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            gap = rx_idle ? $urandom_range(0, 4) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    initial
    begin
        logic signed [15:0] yc;
        logic signed [15:0] xc;
        dir_rows = '{
            '{16'sd0, 16'sd0, 1'b1, 16'sd0},
            '{16'sd1, 16'sd0, 1'b1, ANG_HALF_PI},
            '{-16'sd1, 16'sd0, 1'b1, -ANG_HALF_PI},
            '{16'sd32767, 16'sd0, 1'b1, ANG_HALF_PI},
            '{-16'sd32768, 16'sd0, 1'b1, -ANG_HALF_PI},
            '{16'sd0, 16'sd5, 1'b1, 16'sd0},
            '{16'sd0, 16'sd32767, 1'b1, 16'sd0},
            '{16'sd0, -16'sd5, 1'b1, ANG_PI},
            '{16'sd0, -16'sd32768, 1'b1, ANG_PI},
            '{16'sd100, 16'sd100, 1'b0, 16'sd0},
            '{-16'sd32768, -16'sd32768, 1'b0, 16'sd0},
            '{16'sd32767, -16'sd32767, 1'b0, 16'sd0},
            '{-16'sd7, 16'sd7, 1'b0, 16'sd0},
            '{-16'sd32768, 16'sd32767, 1'b0, 16'sd0},
            '{16'sd32767, -16'sd32768, 1'b0, 16'sd0},
            '{16'sd1, 16'sd32767, 1'b0, 16'sd0},
            '{16'sd32767, 16'sd1, 1'b0, 16'sd0},
            '{-16'sd1, -16'sd32768, 1'b0, 16'sd0},
            '{-16'sd32768, -16'sd1, 1'b0, 16'sd0},
            '{16'sd12345, -16'sd23456, 1'b0, 16'sd0},
            '{-16'sd30000, 16'sd20000, 1'b0, 16'sd0},
            '{16'sd3, -16'sd2, 1'b0, 16'sd0}
        };
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed rows run in the reset mode
        foreach (dir_rows[i])
            send_coords(dir_rows[i].y, dir_rows[i].x, dir_rows[i].fixed, dir_rows[i].angle);
        drain_results();

        for (int p = 0; p < PHASES; p++)
        begin
            set_precision((p % 2) ? MODE_PRECISE : MODE_FAST);
            tx_idle = (p != 2) && (p != 3);
            rx_idle = (p != 2);
            if (p == 3)
                hold_req = 1'b1;
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (i == PHASE_ITEMS / 2)
                    drain_results();
                random_coords(yc, xc);
                send_coords(yc, xc, 1'b0, '0);
            end
            drain_results();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb_polynomial_atan2 OK");
        else
            $display("tb_polynomial_atan2 NOT OK");
        $finish;
    end

endmodule

@@ polynomial_atan2.f @@
rtl/core/patan_pkg.sv
rtl/core/patan_front.sv
rtl/core/patan_fifo.sv
rtl/core/patan_div.sv
rtl/core/patan_poly.sv
rtl/core/polynomial_atan2.sv
test/tb_polynomial_atan2.sv
